FILE: design/bfc_pkg.sv
`default_nettype none

package bfc_pkg;

  // plane storage depth, fixed by the slot encoding
  localparam int PLANE_SLOTS = 6;

  // input opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  // load slot codes for the bounding corners
  localparam logic [2:0] SLOT_MIN = 3'd6;
  localparam logic [2:0] SLOT_MAX = 3'd7;

  // result outcome codes
  localparam logic [1:0] OUTCOME_VISIBLE = 2'd0;
  localparam logic [1:0] OUTCOME_BOUNDS  = 2'd1;
  localparam logic [1:0] OUTCOME_PLANE   = 2'd2;
  localparam logic [1:0] OUTCOME_LOAD    = 2'd3;

  typedef logic signed [31:0] q16_t;
  typedef logic [30:0]        half_t;
  typedef logic [31:0]        mag_t;
  typedef logic signed [63:0] prod_t;
  typedef logic [62:0]        mprod_t;
  typedef logic signed [66:0] usum_t;
  typedef logic [64:0]        vsum_t;
  typedef logic signed [33:0] span_t;

endpackage

`default_nettype wire

FILE: design/box_frustum_cull.sv
`default_nettype none

// box versus frustum culler, one item per cycle when the output is not stalled
// path: an accepted item passes through the stages below before its result is on the out_ ports
// stages: input register, multipliers, plane sums, plane compares, output register
// throughput: one item per cycle; the whole pipe holds while a result waits under out_stall
// reset: rst_n synchronous active low clears valid bits and sets precheck enable
// plane and corner stores are not cleared and read as garbage until loaded
module box_frustum_cull #(
  parameter int PLANE_COUNT = 6
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire                  in_opcode,
  input  wire  [2:0]           in_slot,
  input  wire  bfc_pkg::q16_t  in_coef_x,
  input  wire  bfc_pkg::q16_t  in_coef_y,
  input  wire  bfc_pkg::q16_t  in_coef_z,
  input  wire  bfc_pkg::q16_t  in_coef_w,
  input  wire  bfc_pkg::q16_t  in_center_x,
  input  wire  bfc_pkg::q16_t  in_center_y,
  input  wire  bfc_pkg::q16_t  in_center_z,
  input  wire  bfc_pkg::half_t in_half_x,
  input  wire  bfc_pkg::half_t in_half_y,
  input  wire  bfc_pkg::half_t in_half_z,
  input  wire                  cfg_wr_en,
  input  wire                  cfg_wr_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic                 out_visible,
  output logic [1:0]           out_outcome,
  output logic [2:0]           out_failing_plane
);

  import bfc_pkg::*;

  // planes actually tested
  localparam int NTEST = (PLANE_COUNT < PLANE_SLOTS) ? PLANE_COUNT : PLANE_SLOTS;

  logic adv;
  logic in_take;

  // config register
  logic cfg_pre_r;

  // plane and corner stores
  q16_t pl_n_r [PLANE_SLOTS][3];
  mag_t pl_a_r [PLANE_SLOTS][3];
  q16_t pl_w_r [PLANE_SLOTS];
  q16_t bmin_r [3];
  q16_t bmax_r [3];

  // stage 0: input register
  logic  s0_valid_r, s0_test_r;
  q16_t  s0_c_r [3];
  half_t s0_e_r [3];

  // stage 1: products
  logic   s1_valid_r, s1_test_r, s1_brej_r, s1_brej_nxt;
  prod_t  s1_p_r [NTEST][3];
  prod_t  s1_p_nxt [NTEST][3];
  mprod_t s1_q_r [NTEST][3];
  mprod_t s1_q_nxt [NTEST][3];
  q16_t   s1_w_r [NTEST];

  // stage 2: plane sums
  logic  s2_valid_r, s2_test_r, s2_brej_r;
  usum_t s2_u_r [NTEST];
  usum_t s2_u_nxt [NTEST];
  vsum_t s2_v_r [NTEST];
  vsum_t s2_v_nxt [NTEST];

  // stage 3: plane reject bits
  logic             s3_valid_r, s3_test_r, s3_brej_r;
  logic [NTEST-1:0] s3_prej_r, s3_prej_nxt;

  // output register
  logic       out_valid_r, out_visible_r, out_visible_nxt;
  logic [1:0] out_outcome_r, out_outcome_nxt;
  logic [2:0] out_fp_r, out_fp_nxt;

  // the pipe moves as one whenever the output slot is free or being taken
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign in_take  = in_valid && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_pre_r <= 1'b1;
    end else if (cfg_wr_en) begin
      cfg_pre_r <= cfg_wr_data;
    end
  end

  // store writes at accept, keeping the normal magnitude alongside
  always_ff @(posedge clk) begin
    if (in_take && in_opcode == OP_LOAD) begin
      if (in_slot == SLOT_MIN) begin
        bmin_r[0] <= in_coef_x;
        bmin_r[1] <= in_coef_y;
        bmin_r[2] <= in_coef_z;
      end else if (in_slot == SLOT_MAX) begin
        bmax_r[0] <= in_coef_x;
        bmax_r[1] <= in_coef_y;
        bmax_r[2] <= in_coef_z;
      end else begin
        pl_n_r[in_slot][0] <= in_coef_x;
        pl_n_r[in_slot][1] <= in_coef_y;
        pl_n_r[in_slot][2] <= in_coef_z;
        pl_w_r[in_slot]    <= in_coef_w;
        pl_a_r[in_slot][0] <= in_coef_x[31] ? mag_t'(-in_coef_x) : mag_t'(in_coef_x);
        pl_a_r[in_slot][1] <= in_coef_y[31] ? mag_t'(-in_coef_y) : mag_t'(in_coef_y);
        pl_a_r[in_slot][2] <= in_coef_z[31] ? mag_t'(-in_coef_z) : mag_t'(in_coef_z);
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s0_valid_r  <= in_valid;
      s1_valid_r  <= s0_valid_r;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  // stage 1 logic: bounds precheck and per plane products
  always_comb begin
    span_t lo, hi, mn, mx;
    s1_brej_nxt = 1'b0;
    for (int k = 0; k < 3; k++) begin
      lo = span_t'(s0_c_r[k]) - $signed({3'b000, s0_e_r[k]});
      hi = span_t'(s0_c_r[k]) + $signed({3'b000, s0_e_r[k]});
      mn = span_t'(bmin_r[k]);
      mx = span_t'(bmax_r[k]);
      if (lo > mx || hi < mn) begin
        s1_brej_nxt = 1'b1;
      end
    end
    s1_brej_nxt = s1_brej_nxt && cfg_pre_r;
    for (int i = 0; i < NTEST; i++) begin
      for (int k = 0; k < 3; k++) begin
        s1_p_nxt[i][k] = prod_t'(s0_c_r[k]) * prod_t'(pl_n_r[i][k]);
        s1_q_nxt[i][k] = mprod_t'(pl_a_r[i][k]) * mprod_t'(s0_e_r[k]);
      end
    end
  end

  // stage 2 logic: n.c plus scaled offset, and |n|.e
  always_comb begin
    for (int i = 0; i < NTEST; i++) begin
      s2_u_nxt[i] = usum_t'(s1_p_r[i][0]) + usum_t'(s1_p_r[i][1])
                  + usum_t'(s1_p_r[i][2])
                  + $signed({{19{s1_w_r[i][31]}}, s1_w_r[i], 16'h0000});
      s2_v_nxt[i] = vsum_t'(s1_q_r[i][0]) + vsum_t'(s1_q_r[i][1])
                  + vsum_t'(s1_q_r[i][2]);
    end
  end

  // stage 3 logic: plane rejects when n.c + w - |n|.e is positive
  always_comb begin
    for (int i = 0; i < NTEST; i++) begin
      s3_prej_nxt[i] = $signed({s2_u_r[i][66], s2_u_r[i]}) > $signed({3'b000, s2_v_r[i]});
    end
  end

  // output logic: first rejecting plane wins
  always_comb begin
    out_visible_nxt = 1'b0;
    out_outcome_nxt = OUTCOME_LOAD;
    out_fp_nxt      = 3'd0;
    if (s3_test_r) begin
      if (s3_brej_r) begin
        out_outcome_nxt = OUTCOME_BOUNDS;
      end else if (|s3_prej_r) begin
        out_outcome_nxt = OUTCOME_PLANE;
        for (int i = NTEST - 1; i >= 0; i--) begin
          if (s3_prej_r[i]) begin
            out_fp_nxt = 3'(i);
          end
        end
      end else begin
        out_outcome_nxt = OUTCOME_VISIBLE;
        out_visible_nxt = 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_test_r <= (in_opcode == OP_TEST);
      s0_c_r[0] <= in_center_x;
      s0_c_r[1] <= in_center_y;
      s0_c_r[2] <= in_center_z;
      s0_e_r[0] <= in_half_x;
      s0_e_r[1] <= in_half_y;
      s0_e_r[2] <= in_half_z;

      s1_test_r <= s0_test_r;
      s1_brej_r <= s1_brej_nxt;
      for (int i = 0; i < NTEST; i++) begin
        s1_w_r[i] <= pl_w_r[i];
        for (int k = 0; k < 3; k++) begin
          s1_p_r[i][k] <= s1_p_nxt[i][k];
          s1_q_r[i][k] <= s1_q_nxt[i][k];
        end
      end

      s2_test_r <= s1_test_r;
      s2_brej_r <= s1_brej_r;
      for (int i = 0; i < NTEST; i++) begin
        s2_u_r[i] <= s2_u_nxt[i];
        s2_v_r[i] <= s2_v_nxt[i];
      end

      s3_test_r <= s2_test_r;
      s3_brej_r <= s2_brej_r;
      s3_prej_r <= s3_prej_nxt;

      out_visible_r <= out_visible_nxt;
      out_outcome_r <= out_outcome_nxt;
      out_fp_r      <= out_fp_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_visible       = out_visible_r;
  assign out_outcome       = out_outcome_r;
  assign out_failing_plane = out_fp_r;

`ifndef SYNTHESIS
  // an empty output slot never holds back the input
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> !in_stall)
    else $error("input stalled with empty output register");

  // visible flag agrees with the outcome code
  a_visible_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_visible_r == (out_outcome_r == OUTCOME_VISIBLE)))
    else $error("visible flag and outcome disagree");

  // failing plane index only on a plane reject, and within the tested planes
  a_plane_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_outcome_r == OUTCOME_PLANE) ? (32'(out_fp_r) < NTEST)
                                                      : (out_fp_r == 3'd0)))
    else $error("failing plane index out of place");

  // a load item leaves the pipe as a load acknowledge
  a_load_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s3_valid_r && !s3_test_r) |=> (out_valid_r && out_outcome_r == OUTCOME_LOAD))
    else $error("load item lost its acknowledge");
`endif

endmodule

`default_nettype wire
